// ===== hw/rtl/pose_frame_parser_filter_macros.svh =====
// Assertion macros for the pose frame parser and filter.
// Expects signals clk and arst_n in the scope of each use.
`ifndef POSE_FRAME_PARSER_FILTER_MACROS_SVH
`define POSE_FRAME_PARSER_FILTER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PFP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfp assertion failed");

// Next-cycle implication, disabled while in reset.
`define PFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfp assertion failed");

`endif

// ===== hw/rtl/pfp_pkg.sv =====
// Shared widths, frame constants and control types for the pose frame parser.
// No dependencies; the parser, filter and top modules import it, and the interfaces refer to it.
package pfp_pkg;

	localparam int BYTE_W        = 8;
	localparam int WORD_W        = 32;
	localparam int SPEED_W       = 24;
	localparam int LIMIT_W       = 15;
	localparam int COUNT_W       = 16;
	localparam int SMP_W         = 16;  // a taken sample always fits here
	localparam int PAYLOAD_LEN   = 17;
	localparam int IDX_W         = $clog2(PAYLOAD_LEN);
	localparam int FRAC_BITS_DEF = 8;

	localparam logic [BYTE_W-1:0]  HDR0        = 8'hAA;
	localparam logic [BYTE_W-1:0]  HDR1        = 8'hFF;
	localparam logic [BYTE_W-1:0]  TRL0        = 8'hCD;
	localparam logic [BYTE_W-1:0]  TRL1        = 8'hDC;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd20000;

	// Parser events toward the filters and the result register.
	typedef struct packed {
		logic sum_en;    // first trailer byte transferred: payload complete
		logic frame_ok;  // second trailer byte transferred and matched
		logic at_end;    // waiting for the second trailer byte
	} parse_ctl_t;

endpackage

// ===== hw/rtl/pfp_channel_if.sv =====
// Valid/ready channel interfaces: received bytes in, parsed frame results out.
// Depends on pfp_pkg for field widths.
interface pfp_byte_if;
	logic                      valid;
	logic                      ready;
	logic [pfp_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfp_result_if;
	logic                              valid;
	logic                              ready;
	logic [pfp_pkg::BYTE_W-1:0]         mode;
	logic signed [pfp_pkg::SPEED_W-1:0] speed_x;
	logic signed [pfp_pkg::SPEED_W-1:0] speed_y;
	logic signed [pfp_pkg::WORD_W-1:0]  pose_x;
	logic signed [pfp_pkg::WORD_W-1:0]  pose_y;
	logic                              speed_x_taken;
	logic                              speed_y_taken;
	logic [pfp_pkg::COUNT_W-1:0]        frame_count;

	modport source (output valid, output mode, output speed_x, output speed_y,
		output pose_x, output pose_y, output speed_x_taken, output speed_y_taken,
		output frame_count, input ready);
	modport sink (input valid, input mode, input speed_x, input speed_y,
		input pose_x, input pose_y, input speed_x_taken, input speed_y_taken,
		input frame_count, output ready);
endinterface

// ===== hw/rtl/pose_frame_parser_filter.sv =====
// Pose frame parser with speed low-pass filter, one received byte per cycle but for the stall below.
// The result is registered: it is valid in the cycle after the transfer of the last trailer byte.
// Throughput: one byte per cycle; ready drops only while a result is held unread
// and the last trailer byte is due, the one step that would load the result register.
// Reset clears parser, filters and frame count, and sets the speed limit to 20000.
// Payload bytes need no reset: every frame rewrites all 17 before its trailer.
module pose_frame_parser_filter #(
	parameter int FRAC_BITS = pfp_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	pfp_byte_if.sink                     rx,
	pfp_result_if.source                 res,
	input  logic                         cfg_we,
	input  logic [pfp_pkg::LIMIT_W-1:0]   cfg_wdata
);
	import pfp_pkg::*;

	`include "pose_frame_parser_filter_macros.svh"

	parse_ctl_t              ctl;
	logic                    accept;
	logic [LIMIT_W-1:0]      speed_limit_q;
	logic [COUNT_W-1:0]      frame_cnt_q;
	logic                    out_valid_q;
	logic [BYTE_W-1:0]       mode;
	logic signed [WORD_W-1:0] word_vx, word_vy, word_px, word_py;
	logic signed [SPEED_W-1:0] spd_x_next, spd_y_next;
	logic                    take_x, take_y;

	logic [BYTE_W-1:0]        mode_q;
	logic signed [SPEED_W-1:0] speed_x_q, speed_y_q;
	logic signed [WORD_W-1:0]  pose_x_q, pose_y_q;
	logic                     taken_x_q, taken_y_q;
	logic [COUNT_W-1:0]       count_q;

	// Hold off only the byte that could complete a frame while the result stalls.
	assign rx.ready = !(out_valid_q && !res.ready && ctl.at_end);
	assign accept   = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			speed_limit_q <= cfg_wdata;
		end
	end

	pfp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx.rx_byte),
		.ctl     (ctl),
		.mode    (mode),
		.word_vx (word_vx),
		.word_vy (word_vy),
		.word_px (word_px),
		.word_py (word_py)
	);

	pfp_speed_filter #(.FRAC_BITS(FRAC_BITS)) u_filt_x (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.speed_limit (speed_limit_q),
		.sample      (word_vx),
		.speed_next  (spd_x_next),
		.taken       (take_x)
	);

	pfp_speed_filter #(.FRAC_BITS(FRAC_BITS)) u_filt_y (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.speed_limit (speed_limit_q),
		.sample      (word_vy),
		.speed_next  (spd_y_next),
		.taken       (take_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			frame_cnt_q <= '0;
		end else if (ctl.frame_ok) begin
			out_valid_q <= 1'b1;
			frame_cnt_q <= frame_cnt_q + 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.frame_ok) begin
			mode_q    <= mode;
			speed_x_q <= spd_x_next;
			speed_y_q <= spd_y_next;
			pose_x_q  <= word_px;
			pose_y_q  <= word_py;
			taken_x_q <= take_x;
			taken_y_q <= take_y;
			count_q   <= frame_cnt_q + 1'b1;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.mode          = mode_q;
	assign res.speed_x       = speed_x_q;
	assign res.speed_y       = speed_y_q;
	assign res.pose_x        = pose_x_q;
	assign res.pose_y        = pose_y_q;
	assign res.speed_x_taken = taken_x_q;
	assign res.speed_y_taken = taken_y_q;
	assign res.frame_count   = count_q;

	`PFP_ASSERT_NEXT(a_frame_gives_result, ctl.frame_ok, out_valid_q && count_q == frame_cnt_q)
	`PFP_ASSERT_NEXT(a_count_steps, ctl.frame_ok, frame_cnt_q == COUNT_W'($past(frame_cnt_q) + 1'b1))
	`PFP_ASSERT_NOW(a_stall_only_held, !rx.ready, out_valid_q && ctl.at_end)
	`PFP_ASSERT_NOW(a_no_overwrite, ctl.frame_ok && out_valid_q, res.ready)

endmodule

// ===== hw/rtl/pfp_parser.sv =====
// Byte-serial frame parser: header hunt, 17-byte payload shift line, trailer check.
// Depends on pfp_pkg.
module pfp_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [pfp_pkg::BYTE_W-1:0]        rx_byte,
	output pfp_pkg::parse_ctl_t              ctl,
	output logic [pfp_pkg::BYTE_W-1:0]        mode,
	output logic signed [pfp_pkg::WORD_W-1:0] word_vx,
	output logic signed [pfp_pkg::WORD_W-1:0] word_vy,
	output logic signed [pfp_pkg::WORD_W-1:0] word_px,
	output logic signed [pfp_pkg::WORD_W-1:0] word_py
);
	import pfp_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT0,
		PH_HUNT1,
		PH_PAYLOAD,
		PH_TRL0,
		PH_TRL1
	} phase_t;

	phase_t            phase_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] payload_q [PAYLOAD_LEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT0;
			idx_q   <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_HUNT0: begin
					idx_q <= '0;
					if (rx_byte == HDR0) phase_q <= PH_HUNT1;
				end
				// a bad second header byte is not retried as a first one
				PH_HUNT1: phase_q <= (rx_byte == HDR1) ? PH_PAYLOAD : PH_HUNT0;
				PH_PAYLOAD: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_W'(PAYLOAD_LEN - 1)) phase_q <= PH_TRL0;
				end
				PH_TRL0: phase_q <= (rx_byte == TRL0) ? PH_TRL1 : PH_HUNT0;
				PH_TRL1: phase_q <= PH_HUNT0;
				default: phase_q <= PH_HUNT0;
			endcase
		end
	end

	// Shift payload bytes in; after a full payload, entry 0 holds the first byte.
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_PAYLOAD) begin
			for (int i = 0; i < PAYLOAD_LEN - 1; i++) payload_q[i] <= payload_q[i+1];
			payload_q[PAYLOAD_LEN-1] <= rx_byte;
		end
	end

	always_comb begin
		ctl.sum_en   = accept && (phase_q == PH_TRL0);
		ctl.frame_ok = accept && (phase_q == PH_TRL1) && (rx_byte == TRL1);
		ctl.at_end   = (phase_q == PH_TRL1);
	end

	assign mode    = payload_q[0];
	assign word_vx = $signed({payload_q[4], payload_q[3], payload_q[2], payload_q[1]});
	assign word_vy = $signed({payload_q[8], payload_q[7], payload_q[6], payload_q[5]});
	assign word_px = $signed({payload_q[12], payload_q[11], payload_q[10], payload_q[9]});
	assign word_py = $signed({payload_q[16], payload_q[15], payload_q[14], payload_q[13]});

endmodule

// ===== hw/rtl/pfp_speed_filter.sv =====
// One speed channel: limit check, half-sum low-pass in fixed point, saturation.
// Depends on pfp_pkg; the sum is formed on the first trailer byte, applied on the second.
module pfp_speed_filter #(
	parameter int FRAC_BITS = pfp_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pfp_pkg::parse_ctl_t               ctl,
	input  logic [pfp_pkg::LIMIT_W-1:0]        speed_limit,
	input  logic signed [pfp_pkg::WORD_W-1:0]  sample,
	output logic signed [pfp_pkg::SPEED_W-1:0] speed_next,
	output logic                              taken
);
	import pfp_pkg::*;

	localparam int SUM_W = ((FRAC_BITS + SMP_W + 1 > SPEED_W + 1) ?
		(FRAC_BITS + SMP_W + 1) : (SPEED_W + 1)) + 1;
	localparam int CMP_W = WORD_W + 1;

	logic signed [SPEED_W-1:0] acc_q;
	logic signed [SUM_W-1:0]   sum_s1;
	logic                      take_s1;

	logic signed [CMP_W-1:0] samp_w, lim_p, lim_n;
	logic                    in_range;
	logic signed [SUM_W-1:0] acc_w, smp_w, smp_sh, sum_w, half_w;
	logic [SUM_W-SPEED_W:0]  upper;
	logic signed [SPEED_W-1:0] sat_w;

	always_comb begin
		samp_w   = $signed({sample[WORD_W-1], sample});
		lim_p    = $signed({{(CMP_W-LIMIT_W){1'b0}}, speed_limit});
		lim_n    = -lim_p;
		in_range = (samp_w < lim_p) && (samp_w > lim_n);
		acc_w    = $signed({{(SUM_W-SPEED_W){acc_q[SPEED_W-1]}}, acc_q});
		smp_w    = $signed({{(SUM_W-SMP_W){sample[SMP_W-1]}}, sample[SMP_W-1:0]});
		smp_sh   = smp_w <<< FRAC_BITS;
		sum_w    = acc_w + smp_sh;
	end

	// Floor halving, then clamp to the output range.
	always_comb begin
		half_w = sum_s1 >>> 1;
		upper  = half_w[SUM_W-1:SPEED_W-1];
		if (upper == '0 || upper == '1) begin
			sat_w = half_w[SPEED_W-1:0];
		end else if (half_w[SUM_W-1]) begin
			sat_w = $signed({1'b1, {(SPEED_W-1){1'b0}}});
		end else begin
			sat_w = $signed({1'b0, {(SPEED_W-1){1'b1}}});
		end
		speed_next = take_s1 ? sat_w : acc_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.sum_en) sum_s1 <= sum_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_s1 <= 1'b0;
			acc_q   <= '0;
		end else begin
			if (ctl.sum_en) take_s1 <= in_range;
			if (ctl.frame_ok) acc_q <= speed_next;
		end
	end

	assign taken = take_s1;

endmodule
